[hw/rtl/assert_macros.svh]
// Assertion macros shared by the FDTD block RTL.
// Expects clk_i in the scope of each use, and rst_ni for each ASSERT_RST use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ANY(lbl, prop, msg)
`endif
`endif

[hw/rtl/fdtd_pkg.sv]
// Types, constants and helpers for the 1D lossy-dielectric FDTD block.
// No dependencies; used by every module of the block.
package fdtd_pkg;

  localparam int unsigned CellsDef      = 1024;
  localparam int unsigned SourceCellDef = 5;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned DIFF_W   = FIELD_W + 1;
  localparam int unsigned SAMPLE_W = 26;
  localparam int unsigned P1_W     = COEF_W + FIELD_W;
  localparam int unsigned P2_W     = COEF_W + DIFF_W;
  localparam int unsigned ACC_W    = P2_W + 1;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SHR_W    = ACC_W - FRAC_W;
  localparam int unsigned CFG_DW   = 18;

  // configuration register indexes
  localparam logic [1:0] CFG_DIEL_START = 2'd0;
  localparam logic [1:0] CFG_CA         = 2'd1;
  localparam logic [1:0] CFG_CB         = 2'd2;

  localparam logic [10:0] DIEL_START_RST = 11'd1024;
  localparam logic signed [COEF_W-1:0] CA_RST = 18'sd65536;
  localparam logic [15:0] CB_RST = 16'd32768;

  // coefficients: 1.0 and 0.5 in Q1.16
  localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_HALF = 18'sd32768;
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(32768);

  localparam logic ACT_STEP = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [1:0] {
    OP_E     = 2'd0,
    OP_INJ   = 2'd1,
    OP_PRIME = 2'd2,
    OP_H     = 2'd3
  } op_e;

  typedef struct packed {
    logic valid;
    logic dst_e;
    logic dst_h;
  } mac_ctl_t;

  typedef struct packed {
    mac_ctl_t                   ctl;
    logic signed [COEF_W-1:0]  ca;
    logic signed [FIELD_W-1:0] x;
    logic signed [COEF_W-1:0]  cb;
    logic signed [DIFF_W-1:0]  y;
  } mac_op_t;

  typedef struct packed {
    logic e;
    logic h;
  } wr_en_t;

  localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'(64'sh7FFF_FFFF);
  localparam logic signed [SHR_W-1:0] SAT_MIN = SHR_W'(-64'sh8000_0000);

  function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [SHR_W-1:0] v);
    logic signed [FIELD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/fdtd_mac.sv]
// Shared multiply-accumulate unit: sat(round((ca*x + cb*y) / 2^16)).
// Three register stages; depends on fdtd_pkg.
module fdtd_mac #(
  parameter int unsigned AW = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fdtd_pkg::mac_op_t     op_i,
  input  logic [AW-1:0]         addr_i,
  output fdtd_pkg::mac_ctl_t    res_ctl_o,
  output logic [AW-1:0]         res_addr_o,
  output logic signed [fdtd_pkg::FIELD_W-1:0] res_data_o,
  output logic                  busy_o
);

  fdtd_pkg::mac_ctl_t                  in_ctl_q;
  logic signed [fdtd_pkg::COEF_W-1:0]  in_ca_q, in_cb_q;
  logic signed [fdtd_pkg::FIELD_W-1:0] in_x_q;
  logic signed [fdtd_pkg::DIFF_W-1:0]  in_y_q;
  logic [AW-1:0]      in_addr_q;

  fdtd_pkg::mac_ctl_t prod_ctl_q;
  logic [AW-1:0]      prod_addr_q;
  logic signed [fdtd_pkg::P1_W-1:0] p1_d, p1_q;
  logic signed [fdtd_pkg::P2_W-1:0] p2_d, p2_q;

  logic signed [fdtd_pkg::ACC_W-1:0]   acc;
  logic signed [fdtd_pkg::FIELD_W-1:0] res_d, res_q;
  fdtd_pkg::mac_ctl_t res_ctl_q;
  logic [AW-1:0]      res_addr_q;

  assign p1_d = in_ca_q * in_x_q;
  assign p2_d = in_cb_q * in_y_q;

  // floor after adding one half: ties go up
  assign acc = $signed({{(fdtd_pkg::ACC_W - fdtd_pkg::P1_W){p1_q[fdtd_pkg::P1_W-1]}}, p1_q})
             + $signed({p2_q[fdtd_pkg::P2_W-1], p2_q})
             + fdtd_pkg::ROUND_HALF;
  assign res_d = fdtd_pkg::sat_field($signed(acc[fdtd_pkg::ACC_W-1:fdtd_pkg::FRAC_W]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q   <= '0;
      prod_ctl_q <= '0;
      res_ctl_q  <= '0;
    end else begin
      in_ctl_q   <= op_i.ctl;
      prod_ctl_q <= in_ctl_q;
      res_ctl_q  <= prod_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_ca_q     <= op_i.ca;
    in_x_q      <= op_i.x;
    in_cb_q     <= op_i.cb;
    in_y_q      <= op_i.y;
    in_addr_q   <= addr_i;
    p1_q        <= p1_d;
    p2_q        <= p2_d;
    prod_addr_q <= in_addr_q;
    res_q       <= res_d;
    res_addr_q  <= prod_addr_q;
  end

  assign res_ctl_o  = res_ctl_q;
  assign res_addr_o = res_addr_q;
  assign res_data_o = res_q;
  assign busy_o     = in_ctl_q.valid | prod_ctl_q.valid | res_ctl_q.valid;

endmodule

[hw/rtl/fdtd_store.sv]
// E and H field memories: one write port shared by both, one read port each.
// Read data is registered; depends on fdtd_pkg.
module fdtd_store #(
  parameter int unsigned CELLS = fdtd_pkg::CellsDef,
  parameter int unsigned AW    = $clog2(CELLS)
) (
  input  logic                  clk_i,
  input  fdtd_pkg::wr_en_t      we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic signed [fdtd_pkg::FIELD_W-1:0] wdata_i,
  input  logic [AW-1:0]         e_raddr_i,
  input  logic [AW-1:0]         h_raddr_i,
  output logic signed [fdtd_pkg::FIELD_W-1:0] e_rdata_o,
  output logic signed [fdtd_pkg::FIELD_W-1:0] h_rdata_o
);

  logic signed [fdtd_pkg::FIELD_W-1:0] e_mem [CELLS];
  logic signed [fdtd_pkg::FIELD_W-1:0] h_mem [CELLS];
  logic signed [fdtd_pkg::FIELD_W-1:0] e_rdata_q, h_rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i.e) begin
      e_mem[waddr_i] <= wdata_i;
    end
    e_rdata_q <= e_mem[e_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.h) begin
      h_mem[waddr_i] <= wdata_i;
    end
    h_rdata_q <= h_mem[h_raddr_i];
  end

  assign e_rdata_o = e_rdata_q;
  assign h_rdata_o = h_rdata_q;

endmodule

[hw/rtl/fdtd_1d_lossy_dielectric_step_top.sv]
// Top level of the 1D lossy-dielectric FDTD block: sequencer, config registers.
// Depends on fdtd_pkg, fdtd_mac, fdtd_store and assert_macros.svh.
//
//   channel   handshake              payload
//   --------  ---------------------  ---------------------------------------
//   command   start / busy           action_i, source_sample_i, cell_index_i
//   result    done_o (1-cycle pulse) e_value_o, h_value_o
//   config    cfg_we_i               cfg_index_i, cfg_data_i
//
// After reset a clearing pass zeroes both field memories with busy high. A
// read transaction reads its cell in S_RESP and has done_o high in S_OUT. A
// step transaction runs an E pass (CELLS cells) and an H pass (CELLS - 1
// cells), one cell per cycle through the single shared MAC, with a drain
// after the E pass, the source update and the H pass, then reads the source
// cell in S_RESP and has done_o high in S_OUT. The result pulse cannot
// be stalled; a new command is taken once busy drops.
`include "assert_macros.svh"

module fdtd_1d_lossy_dielectric_step_top #(
  parameter int unsigned CELLS       = fdtd_pkg::CellsDef,
  parameter int unsigned SOURCE_CELL = fdtd_pkg::SourceCellDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action_i,
  input  logic signed [25:0]    source_sample_i,
  input  logic [9:0]            cell_index_i,
  output logic                  done_o,
  output logic signed [31:0]    e_value_o,
  output logic signed [31:0]    h_value_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [fdtd_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(CELLS);
  localparam logic [AW-1:0] SRC_ADDR   = AW'(SOURCE_CELL);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_HCELL = AW'(CELLS - 2);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EPASS  = 4'd2;
  localparam logic [3:0] S_EDRAIN = 4'd3;
  localparam logic [3:0] S_INJ    = 4'd4;
  localparam logic [3:0] S_IDRAIN = 4'd5;
  localparam logic [3:0] S_HPRIME = 4'd6;
  localparam logic [3:0] S_HPASS  = 4'd7;
  localparam logic [3:0] S_HDRAIN = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  // configuration
  logic [10:0]                          diel_start_q;
  logic signed [fdtd_pkg::COEF_W-1:0]   ca_q;
  logic [15:0]                          cb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diel_start_q <= fdtd_pkg::DIEL_START_RST;
      ca_q         <= fdtd_pkg::CA_RST;
      cb_q         <= fdtd_pkg::CB_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fdtd_pkg::CFG_DIEL_START: diel_start_q <= cfg_data_i[10:0];
        fdtd_pkg::CFG_CA:         ca_q <= $signed(cfg_data_i[fdtd_pkg::COEF_W-1:0]);
        fdtd_pkg::CFG_CB:         cb_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] raddr_q, raddr_d;
  logic          oob_q, oob_d;
  logic signed [fdtd_pkg::SAMPLE_W-1:0] sample_q;
  logic          accept;
  logic          pipe_empty;
  logic          mac_busy;

  // issue stage: address sent to memory, data back next cycle
  logic          s1_valid_q, s1_valid_d;
  fdtd_pkg::op_e s1_kind_q, s1_kind_d;
  logic [AW-1:0] s1_addr_q, s1_addr_d;

  logic [AW-1:0] e_raddr, h_raddr;
  logic signed [fdtd_pkg::FIELD_W-1:0] e_rdata, h_rdata;
  logic signed [fdtd_pkg::FIELD_W-1:0] hprev_q, eprev_q, hl;

  fdtd_pkg::mac_op_t  mac_op;
  fdtd_pkg::mac_ctl_t res_ctl;
  logic [AW-1:0]      res_addr;
  logic signed [fdtd_pkg::FIELD_W-1:0] res_data;

  fdtd_pkg::wr_en_t   wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [fdtd_pkg::FIELD_W-1:0] wr_data;

  assign accept     = start && !busy;
  assign pipe_empty = !s1_valid_q && !mac_busy;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    raddr_d    = raddr_q;
    oob_d      = oob_q;
    s1_valid_d = 1'b0;
    s1_kind_d  = fdtd_pkg::OP_E;
    s1_addr_d  = k_q;
    e_raddr    = '0;
    h_raddr    = '0;
    unique case (state_q)
      S_CLEAR: begin
        k_d = k_q + 1'b1;
        if (k_q == LAST_CELL) begin
          k_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          k_d = '0;
          if (action_i == fdtd_pkg::ACT_READ) begin
            raddr_d = AW'(cell_index_i);
            oob_d   = !(32'(cell_index_i) < 32'(CELLS));
            state_d = S_RESP;
          end else begin
            raddr_d = SRC_ADDR;
            oob_d   = 1'b0;
            state_d = S_EPASS;
          end
        end
      end
      S_EPASS: begin
        e_raddr    = k_q;
        h_raddr    = k_q;
        s1_valid_d = 1'b1;
        s1_kind_d  = fdtd_pkg::OP_E;
        k_d        = k_q + 1'b1;
        if (k_q == LAST_CELL) begin
          k_d     = '0;
          state_d = S_EDRAIN;
        end
      end
      S_EDRAIN: begin
        if (pipe_empty) begin
          state_d = S_INJ;
        end
      end
      S_INJ: begin
        e_raddr    = SRC_ADDR;
        s1_valid_d = 1'b1;
        s1_kind_d  = fdtd_pkg::OP_INJ;
        s1_addr_d  = SRC_ADDR;
        state_d    = S_IDRAIN;
      end
      S_IDRAIN: begin
        if (pipe_empty) begin
          state_d = S_HPRIME;
        end
      end
      S_HPRIME: begin
        // load E of cell 0 so each H op sees E left and right
        e_raddr    = '0;
        s1_valid_d = 1'b1;
        s1_kind_d  = fdtd_pkg::OP_PRIME;
        state_d    = S_HPASS;
      end
      S_HPASS: begin
        e_raddr    = k_q + 1'b1;
        h_raddr    = k_q;
        s1_valid_d = 1'b1;
        s1_kind_d  = fdtd_pkg::OP_H;
        k_d        = k_q + 1'b1;
        if (k_q == LAST_HCELL) begin
          k_d     = '0;
          state_d = S_HDRAIN;
        end
      end
      S_HDRAIN: begin
        if (pipe_empty) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        e_raddr = raddr_q;
        h_raddr = raddr_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      k_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q   <= raddr_d;
    oob_q     <= oob_d;
    s1_kind_q <= s1_kind_d;
    s1_addr_q <= s1_addr_d;
    if (accept) begin
      sample_q <= source_sample_i;
    end
    if (s1_valid_q && s1_kind_q == fdtd_pkg::OP_E) begin
      hprev_q <= h_rdata;
    end
    if (s1_valid_q && (s1_kind_q == fdtd_pkg::OP_PRIME || s1_kind_q == fdtd_pkg::OP_H)) begin
      eprev_q <= e_rdata;
    end
  end

  // operand selection for the shared MAC
  assign hl = (s1_addr_q == '0) ? '0 : hprev_q;

  always_comb begin
    mac_op.ctl.valid = s1_valid_q && (s1_kind_q != fdtd_pkg::OP_PRIME);
    mac_op.ctl.dst_e = (s1_kind_q == fdtd_pkg::OP_E) || (s1_kind_q == fdtd_pkg::OP_INJ);
    mac_op.ctl.dst_h = (s1_kind_q == fdtd_pkg::OP_H);
    mac_op.ca = fdtd_pkg::COEF_ONE;
    mac_op.x  = e_rdata;
    mac_op.cb = fdtd_pkg::COEF_ONE;
    mac_op.y  = '0;
    unique case (s1_kind_q)
      fdtd_pkg::OP_E: begin
        if (32'(s1_addr_q) >= 32'(diel_start_q)) begin
          mac_op.ca = ca_q;
          mac_op.cb = $signed({2'b00, cb_q});
        end else begin
          mac_op.ca = fdtd_pkg::COEF_ONE;
          mac_op.cb = fdtd_pkg::COEF_HALF;
        end
        mac_op.y = $signed({hl[31], hl}) - $signed({h_rdata[31], h_rdata});
      end
      fdtd_pkg::OP_INJ: begin
        mac_op.y = $signed({{(fdtd_pkg::DIFF_W - fdtd_pkg::SAMPLE_W){sample_q[25]}}, sample_q});
      end
      fdtd_pkg::OP_H: begin
        // H + (E - Eright)/2 rounded up on ties, as 1.0*H + 0.5*diff
        mac_op.x  = h_rdata;
        mac_op.cb = fdtd_pkg::COEF_HALF;
        mac_op.y  = $signed({eprev_q[31], eprev_q}) - $signed({e_rdata[31], e_rdata});
      end
      fdtd_pkg::OP_PRIME: begin
        mac_op.y = '0;
      end
      default: begin
        mac_op.y = '0;
      end
    endcase
  end

  fdtd_mac #(
    .AW(AW)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (mac_op),
    .addr_i     (s1_addr_q),
    .res_ctl_o  (res_ctl),
    .res_addr_o (res_addr),
    .res_data_o (res_data),
    .busy_o     (mac_busy)
  );

  // clearing pass owns the write port until idle
  always_comb begin
    if (state_q == S_CLEAR) begin
      wr_en.e = 1'b1;
      wr_en.h = 1'b1;
      wr_addr = k_q;
      wr_data = '0;
    end else begin
      wr_en.e = res_ctl.valid && res_ctl.dst_e;
      wr_en.h = res_ctl.valid && res_ctl.dst_h;
      wr_addr = res_addr;
      wr_data = res_data;
    end
  end

  fdtd_store #(
    .CELLS(CELLS),
    .AW   (AW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .e_raddr_i (e_raddr),
    .h_raddr_i (h_raddr),
    .e_rdata_o (e_rdata),
    .h_rdata_o (h_rdata)
  );

  assign busy      = (state_q != S_IDLE);
  assign done_o    = (state_q == S_OUT);
  assign e_value_o = oob_q ? '0 : e_rdata;
  assign h_value_o = oob_q ? '0 : h_rdata;

  `ASSERT_RST(a_done_follows_busy, done_o |-> $past(busy), "result pulse without a busy cycle before it")
  `ASSERT_RST(a_accept_sets_busy, accept |=> busy, "accepted transaction did not raise busy")
  `ASSERT_ANY(a_write_in_range, (wr_en.e || wr_en.h) |-> (32'(wr_addr) < 32'(CELLS)), "field write beyond the grid")
  `ASSERT_RST(a_idle_no_write, (state_q == S_IDLE) |-> !(wr_en.e || wr_en.h), "field write while idle, pipeline not drained")

endmodule
